### sv/oorf_pkg.sv
// ----------------------------------------------------------------------------
// Overwrite-oldest ring FIFO package
// Shared types for the controller and the datapath of the ring FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package oorf_pkg;

  // Operation carried in the action field of an input word.
  typedef enum logic [0:0] {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // an input word is taken this cycle
    logic is_pop;     // the accepted word requests a pop
    logic load_rdata; // capture the memory read data into the result
    logic cfg_write;  // capacity write, flushes the FIFO
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
  } status_t;

endpackage

`default_nettype wire

### sv/oorf_if.sv
// ----------------------------------------------------------------------------
// Overwrite-oldest ring FIFO channels
// Valid/ready channels for input words, result words and capacity writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface oorf_in_if #(
  parameter int ITEM_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [ITEM_WIDTH-1:0] push_data;

  modport source (output valid, output action, output push_data, input ready);
  modport sink   (input valid, input action, input push_data, output ready);
endinterface

interface oorf_out_if #(
  parameter int ITEM_WIDTH = 32,
  parameter int CNT_W      = 5
);
  logic                  valid;
  logic                  ready;
  logic [ITEM_WIDTH-1:0] pop_data;
  logic                  pop_ok;
  logic                  overwrote;
  logic [CNT_W-1:0]      fill_count;
  logic                  is_full;
  logic                  is_empty;

  modport source (output valid, output pop_data, output pop_ok, output overwrote,
                  output fill_count, output is_full, output is_empty, input ready);
  modport sink   (input valid, input pop_data, input pop_ok, input overwrote,
                  input fill_count, input is_full, input is_empty, output ready);
endinterface

interface oorf_cfg_if #(
  parameter int CNT_W = 5
);
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

### sv/overwrite_oldest_ring_fifo.sv
// ----------------------------------------------------------------------------
// Overwrite-oldest ring FIFO
// Circular FIFO with a configurable capacity that drops its oldest word when
// a push arrives while full.
// ----------------------------------------------------------------------------
// Each input word yields exactly one result word. A push, and a pop on an
// empty FIFO, produce their result in the cycle after acceptance; a pop that
// returns data first passes the read state for the registered read of the
// item memory. A result waits in an output register, and the next input word
// is accepted in the cycle in which that result is taken, so pushes run at one
// word per cycle while results are taken; a data pop takes no new word during
// its read. A capacity write is taken in any cycle and empties the FIFO; an
// input word offered with it waits. There is no clearing pass after reset.
`default_nettype none

module overwrite_oldest_ring_fifo #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  oorf_in_if.sink    in_ch,
  oorf_out_if.source out_ch,
  oorf_cfg_if.sink   cfg_ch
);
  import oorf_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t    cmd;
  status_t status;

  oorf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_action_i (in_ch.action),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_ready_o (cfg_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  oorf_dp #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .push_data_i    (in_ch.push_data),
    .cfg_capacity_i (cfg_ch.capacity),
    .pop_data_o     (out_ch.pop_data),
    .pop_ok_o       (out_ch.pop_ok),
    .overwrote_o    (out_ch.overwrote),
    .fill_count_o   (out_ch.fill_count),
    .is_full_o      (out_ch.is_full),
    .is_empty_o     (out_ch.is_empty)
  );

endmodule

`default_nettype wire

### sv/oorf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module oorf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/oorf_ctrl.sv
// ----------------------------------------------------------------------------
// Overwrite-oldest ring FIFO controller
// Sequences acceptance, the memory read of a pop and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module oorf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_action_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire oorf_pkg::status_t status_i,
  output oorf_pkg::cmd_t         cmd_o
);
  import oorf_pkg::*;

  state_e state_q, state_d;
  logic   accept;
  logic   is_pop;

  // A new word may enter while the previous result is being taken.
  // A capacity write takes precedence over an input word.
  assign in_ready_o  = ((state_q == ST_IDLE) || ((state_q == ST_OUT) && out_ready_i))
                       && !cfg_valid_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == ST_OUT);

  assign accept = in_valid_i && in_ready_o;
  assign is_pop = (action_e'(in_action_i) == ACT_POP);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (is_pop && !status_i.empty) ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (accept) begin
          state_d = (is_pop && !status_i.empty) ? ST_READ : ST_OUT;
        end else if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o.accept     = accept;
    cmd_o.is_pop     = is_pop;
    cmd_o.load_rdata = (state_q == ST_READ);
    cmd_o.cfg_write  = cfg_valid_i && cfg_ready_o;
  end

endmodule

`default_nettype wire

### sv/oorf_dp.sv
// ----------------------------------------------------------------------------
// Overwrite-oldest ring FIFO datapath
// Pointers, fill count, capacity register, item memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oorf_dp #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire oorf_pkg::cmd_t        cmd_i,
  output oorf_pkg::status_t          status_o,
  input  wire logic [ITEM_WIDTH-1:0] push_data_i,
  input  wire logic [CNT_W-1:0]      cfg_capacity_i,
  output logic      [ITEM_WIDTH-1:0] pop_data_o,
  output logic                       pop_ok_o,
  output logic                       overwrote_o,
  output logic      [CNT_W-1:0]      fill_count_o,
  output logic                       is_full_o,
  output logic                       is_empty_o
);
  import oorf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic [PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      cap_q, cap_d;
  logic [ITEM_WIDTH-1:0] pop_data_q;
  logic                  pop_ok_q, ovw_q, full_q, empty_q;
  logic [CNT_W-1:0]      fill_q;
  logic                  ovw_d, ok_d;
  logic                  full;
  logic                  do_push, do_pop;
  logic [ITEM_WIDTH-1:0] rdata;

  // Pointer increment wrapping at the effective capacity.
  function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p, logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

  // A capacity of zero behaves as one and anything beyond the depth as the depth.
  always_comb begin
    priority if (cfg_capacity_i == '0) begin
      cap_d = CNT_W'(1);
    end else if (cfg_capacity_i > CNT_W'(DEPTH)) begin
      cap_d = CNT_W'(DEPTH);
    end else begin
      cap_d = cfg_capacity_i;
    end
  end

  assign full    = (cnt_q >= cap_q);
  assign do_push = cmd_i.accept && !cmd_i.is_pop;
  assign do_pop  = cmd_i.accept && cmd_i.is_pop && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    ovw_d    = 1'b0;
    ok_d     = 1'b0;
    priority if (cmd_i.cfg_write) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      cnt_d    = '0;
    end else if (do_push) begin
      wr_ptr_d = advance(wr_ptr_q, cap_q);
      if (full) begin
        // The oldest word is dropped to make room.
        rd_ptr_d = advance(rd_ptr_q, cap_q);
        ovw_d    = 1'b1;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end else if (do_pop) begin
      rd_ptr_d = advance(rd_ptr_q, cap_q);
      cnt_d    = cnt_q - CNT_W'(1);
      ok_d     = 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      cap_q    <= CNT_W'(DEPTH);
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      if (cmd_i.cfg_write) begin
        cap_q <= cap_d;
      end
    end
  end

  // Result register; the popped word arrives in the cycle after the flags.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pop_data_q <= '0;
      pop_ok_q   <= ok_d;
      ovw_q      <= ovw_d;
      fill_q     <= cnt_d;
      full_q     <= (cnt_d == cap_q);
      empty_q    <= (cnt_d == '0);
    end else if (cmd_i.load_rdata) begin
      pop_data_q <= rdata;
    end
  end

  oorf_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (wr_ptr_q),
    .wdata_i (push_data_i),
    .re_i    (do_pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = pop_data_q;
  assign pop_ok_o       = pop_ok_q;
  assign overwrote_o    = ovw_q;
  assign fill_count_o   = fill_q;
  assign is_full_o      = full_q;
  assign is_empty_o     = empty_q;

endmodule

`default_nettype wire

### sv/oorf_checker.sv
// ----------------------------------------------------------------------------
// Overwrite-oldest ring FIFO checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module oorf_checker #(
  parameter int ITEM_WIDTH = 32,
  parameter int CNT_W      = 5
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire logic [ITEM_WIDTH-1:0] pop_data_i,
  input wire logic                  pop_ok_i,
  input wire logic                  overwrote_i,
  input wire logic [CNT_W-1:0]      fill_count_i,
  input wire logic                  is_full_i,
  input wire logic                  is_empty_i
);

  // A stalled result word must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pop_data_i)
      && $stable(fill_count_i) && $stable(pop_ok_i) && $stable(overwrote_i))
    else $error("result word changed while stalled");

  // A successful pop cannot also overwrite, and leaves room behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pop_ok_i |-> !overwrote_i && !is_full_i)
    else $error("pop reported overwrite or full");

  // An overwrite only happens on a full FIFO, which stays full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overwrote_i |-> is_full_i && !is_empty_i)
    else $error("overwrite without full FIFO");

  // The empty flag follows the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_empty_i == (fill_count_i == '0)))
    else $error("empty flag disagrees with fill count");

endmodule

bind overwrite_oldest_ring_fifo oorf_checker #(
  .ITEM_WIDTH (ITEM_WIDTH),
  .CNT_W      (CNT_W)
) u_oorf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .pop_data_i   (out_ch.pop_data),
  .pop_ok_i     (out_ch.pop_ok),
  .overwrote_i  (out_ch.overwrote),
  .fill_count_i (out_ch.fill_count),
  .is_full_i    (out_ch.is_full),
  .is_empty_i   (out_ch.is_empty)
);

`default_nettype wire

### sim/overwrite_oldest_ring_fifo_tb.sv
// ----------------------------------------------------------------------------
// Overwrite-oldest ring FIFO testbench
// Drives push and pop words through the FIFO under several capacity settings.
// Each accepted word goes into a scoreboard that keeps its own ring state.
// Every result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

import oorf_pkg::*;

typedef struct packed {
  logic [31:0] pop_data;
  logic        pop_ok;
  logic        overwrote;
  logic [4:0]  fill_count;
  logic        is_full;
  logic        is_empty;
} fifo_result_t;

class fifo_scoreboard;
  localparam int unsigned SLOTS = 16;

  logic [31:0]  slots [SLOTS];
  logic [4:0]   capacity_reg;
  int unsigned  wr_ptr;
  int unsigned  rd_ptr;
  int unsigned  held;
  fifo_result_t pending_results[$];

  int unsigned  errors;
  int unsigned  checked;
  int unsigned  pushes;
  int unsigned  pops;
  int unsigned  overwrites;
  int unsigned  empty_pops;
  int unsigned  settings;

  function new();
    capacity_reg = 5'd16;
    wr_ptr = 0;
    rd_ptr = 0;
    held = 0;
    errors = 0;
    checked = 0;
    pushes = 0;
    pops = 0;
    overwrites = 0;
    empty_pops = 0;
    settings = 1;
  endfunction

  // A zero register acts as one slot; anything above the built depth saturates.
  function int unsigned usable_slots();
    int unsigned c;
    c = capacity_reg;
    if (c == 0) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  function int unsigned step_ptr(int unsigned p, int unsigned lim);
    return (p + 1 >= lim) ? 0 : p + 1;
  endfunction

  // Any write of the register empties the ring.
  function void load_capacity(logic [4:0] value);
    capacity_reg = value;
    wr_ptr = 0;
    rd_ptr = 0;
    held = 0;
    settings++;
  endfunction

  function void note_word(logic act, logic [31:0] data);
    fifo_result_t r;
    int unsigned  lim;
    lim = usable_slots();
    r = '0;
    if (act == ACT_PUSH) begin
      pushes++;
      slots[wr_ptr] = data;
      wr_ptr = step_ptr(wr_ptr, lim);
      if (held >= lim) begin
        rd_ptr = step_ptr(rd_ptr, lim);
        r.overwrote = 1'b1;
        overwrites++;
      end else begin
        held++;
      end
    end else begin
      pops++;
      if (held > 0) begin
        r.pop_data = slots[rd_ptr];
        rd_ptr = step_ptr(rd_ptr, lim);
        held--;
        r.pop_ok = 1'b1;
      end else begin
        empty_pops++;
      end
    end
    r.fill_count = held[4:0];
    r.is_full    = (held == lim);
    r.is_empty   = (held == 0);
    pending_results.push_back(r);
  endfunction

  function void check_result(fifo_result_t got);
    fifo_result_t want;
    bit           bad;
    checked++;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: result word with nothing predicted: %p", got);
      return;
    end
    want = pending_results.pop_front();
    bad = (got.pop_data !== want.pop_data) || (got.pop_ok !== want.pop_ok) ||
          (got.overwrote !== want.overwrote) || (got.fill_count !== want.fill_count) ||
          (got.is_full !== want.is_full) || (got.is_empty !== want.is_empty);
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: result %0d differs", checked);
        $display("  expected data=%h ok=%b ovw=%b fill=%0d full=%b empty=%b",
                 want.pop_data, want.pop_ok, want.overwrote, want.fill_count,
                 want.is_full, want.is_empty);
        $display("  actual   data=%h ok=%b ovw=%b fill=%0d full=%b empty=%b",
                 got.pop_data, got.pop_ok, got.overwrote, got.fill_count,
                 got.is_full, got.is_empty);
      end
    end
  endfunction

  function int unsigned outstanding();
    return pending_results.size();
  endfunction
endclass

module overwrite_oldest_ring_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni;

  oorf_in_if  #(.ITEM_WIDTH(32))             in_if ();
  oorf_out_if #(.ITEM_WIDTH(32), .CNT_W(5))  out_if ();
  oorf_cfg_if #(.CNT_W(5))                   cfg_if ();

  overwrite_oldest_ring_fifo #(
    .DEPTH     (16),
    .ITEM_WIDTH(32)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  fifo_scoreboard sb;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [31:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_word(logic act, logic [31:0] data);
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.push_data <= data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_word(act, data);
  endtask

  task automatic idle_in(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
  endtask

  // Stop offering words and wait until every predicted result has been taken.
  task automatic drain();
    idle_in(1);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] value);
    drain();
    @(negedge clk_i);
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.load_capacity(value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(int unsigned n_words, int unsigned push_pct, bit no_gaps,
                           bit hold_off);
    logic act;
    for (int unsigned i = 0; i < n_words; i++) begin
      act = ($urandom_range(1, 100) <= push_pct) ? ACT_PUSH : ACT_POP;
      send_word(act, pick_data());
      if (!no_gaps) idle_in(pick_gap());
      if (hold_off && i == n_words / 2) drain();
    end
  endtask

  // Result side: ready runs high for a while, then drops for a random gap.
  initial begin
    int unsigned run_len;
    int unsigned gap;
    out_if.ready <= 1'b0;
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                            : $urandom_range(1, 10);
      repeat (run_len) begin
        @(negedge clk_i);
        out_if.ready <= 1'b1;
      end
      gap = pick_gap();
      repeat (gap) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    fifo_result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.pop_data   = out_if.pop_data;
      got.pop_ok     = out_if.pop_ok;
      got.overwrote  = out_if.overwrote;
      got.fill_count = out_if.fill_count;
      got.is_full    = out_if.is_full;
      got.is_empty   = out_if.is_empty;
      sb.check_result(got);
    end
  end

  initial begin
    int unsigned push_mix [10] = '{75, 60, 85, 50, 40, 65, 90, 55, 30, 70};
    logic [4:0]  cap_plan [10];
    int unsigned leftover;
    sb = new();
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.action    <= ACT_PUSH;
    in_if.push_data <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.capacity <= '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset capacity: pop on empty, extreme data values, drain to empty again.
    send_word(ACT_POP, 32'hDEAD_BEEF);
    send_word(ACT_PUSH, 32'h0000_0000);
    send_word(ACT_PUSH, 32'hFFFF_FFFF);
    send_word(ACT_PUSH, 32'h5A5A_A5A5);
    repeat (4) send_word(ACT_POP, 32'h1234_5678);

    // A zero capacity behaves as a single slot, so the second push overwrites.
    write_capacity(5'd0);
    send_word(ACT_PUSH, 32'h0000_0001);
    send_word(ACT_PUSH, 32'h0000_0002);
    send_word(ACT_POP, 32'h0);
    send_word(ACT_POP, 32'h0);

    // Small ring: overwrite with wrap, then leave one word held.
    write_capacity(5'd3);
    for (int unsigned i = 0; i < 4; i++) send_word(ACT_PUSH, 32'hA000_0000 + i);
    send_word(ACT_POP, 32'h0);
    send_word(ACT_POP, 32'h0);

    // The held word must be gone once the register is rewritten.
    write_capacity(5'd31);
    send_word(ACT_POP, 32'h0);
    send_word(ACT_PUSH, 32'hC0DE_0001);
    send_word(ACT_PUSH, 32'hC0DE_0002);
    send_word(ACT_POP, 32'h0);

    cap_plan = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'($urandom_range(3, 15)),
                 5'd17, 5'($urandom_range(0, 31)), 5'd5, 5'd16};
    for (int unsigned p = 0; p < 10; p++) begin
      write_capacity(cap_plan[p]);
      run_phase(63, push_mix[p], (p % 4) == 1, p == 3 || p == 7);
    end

    drain();
    repeat (10) @(posedge clk_i);
    leftover = sb.outstanding();
    $display("Run: %0d words (%0d pushes, %0d pops, %0d overwrites, %0d empty pops)",
             sb.pushes + sb.pops, sb.pushes, sb.pops, sb.overwrites, sb.empty_pops);
    $display("over %0d capacity settings; %0d results checked, %0d still outstanding",
             sb.settings, sb.checked, leftover);
    if (sb.errors == 0 && leftover == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: stimulus or results stalled");
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/oorf_pkg.sv
sv/oorf_if.sv
sv/oorf_ram.sv
sv/oorf_ctrl.sv
sv/oorf_dp.sv
sv/overwrite_oldest_ring_fifo.sv
sv/oorf_checker.sv
sim/overwrite_oldest_ring_fifo_tb.sv
